/* rtl/dmwbc_pkg.sv */
package dmwbc_pkg;

  localparam int NUM_SETS        = 64;
  localparam int WORDS_PER_BLOCK = 8;
  localparam int SET_BITS        = $clog2(NUM_SETS);
  localparam int WORD_BITS       = $clog2(WORDS_PER_BLOCK);
  localparam int OFF_BITS        = WORD_BITS + 2;
  localparam int LINE_WORDS      = NUM_SETS * WORDS_PER_BLOCK;
  localparam int IDX_BITS        = SET_BITS + WORD_BITS;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_WB   = 2'd1;
  localparam logic [1:0] KIND_REQ  = 2'd2;

  typedef struct packed {
    logic       load_req;
    logic       rd_lookup;
    logic       rd_wb;
    logic       rd_fill;
    logic       hit_store;
    logic       miss;
    logic       fill_write;
    logic       fill_finish;
    logic       fill_store;
    logic       fill_load;
    logic       inc_rq;
    logic       inc_wq;
    logic       wb_adv;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_hit;
    logic       emit_last;
    logic       emit_rdata;
  } dmwbc_ctl_t;

  typedef struct packed {
    logic [1:0] req_cmd;
    logic       pending;
    logic       hit;
    logic       victim_dirty;
    logic       fill_last;
    logic       wb_last;
    logic       pend_is_load;
    logic       out_free;
  } dmwbc_stat_t;

endpackage

/* rtl/dmwbc_ctrl.sv */
module dmwbc_ctrl
  import dmwbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  dmwbc_stat_t st,
  output dmwbc_ctl_t  ctl
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_READ      = 3'd1;
  localparam logic [2:0] S_COMPARE   = 3'd2;
  localparam logic [2:0] S_WB_READ   = 3'd3;
  localparam logic [2:0] S_WB_EMIT   = 3'd4;
  localparam logic [2:0] S_REQ       = 3'd5;
  localparam logic [2:0] S_FILL_READ = 3'd6;
  localparam logic [2:0] S_FILL_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_req = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        ctl.rd_lookup = 1'b1;
        state_next    = S_COMPARE;
      end
      S_COMPARE: begin
        case (st.req_cmd)
          CMD_LOAD, CMD_STORE: begin
            if (st.pending) begin
              state_next = S_IDLE;
            end else if (st.hit) begin
              if (st.out_free) begin
                ctl.emit       = 1'b1;
                ctl.emit_kind  = KIND_DONE;
                ctl.emit_hit   = 1'b1;
                ctl.emit_last  = 1'b1;
                ctl.emit_rdata = (st.req_cmd == CMD_LOAD);
                ctl.inc_rq     = (st.req_cmd == CMD_LOAD);
                ctl.inc_wq     = (st.req_cmd == CMD_STORE);
                ctl.hit_store  = (st.req_cmd == CMD_STORE);
                state_next     = S_IDLE;
              end
            end else begin
              ctl.miss   = 1'b1;
              state_next = st.victim_dirty ? S_WB_READ : S_REQ;
            end
          end
          CMD_FILL: begin
            if (!st.pending) begin
              state_next = S_IDLE;
            end else begin
              ctl.fill_write = 1'b1;
              if (st.fill_last) begin
                ctl.fill_finish = 1'b1;
                state_next      = S_FILL_READ;
              end else begin
                state_next = S_IDLE;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WB_READ: begin
        ctl.rd_wb  = 1'b1;
        state_next = S_WB_EMIT;
      end
      S_WB_EMIT: begin
        if (st.out_free) begin
          ctl.emit       = 1'b1;
          ctl.emit_kind  = KIND_WB;
          ctl.emit_rdata = 1'b1;
          ctl.wb_adv     = 1'b1;
          state_next     = st.wb_last ? S_REQ : S_WB_READ;
        end
      end
      S_REQ: begin
        if (st.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_kind = KIND_REQ;
          ctl.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FILL_READ: begin
        ctl.rd_fill = 1'b1;
        state_next  = S_FILL_EMIT;
      end
      S_FILL_EMIT: begin
        if (st.out_free) begin
          ctl.emit       = 1'b1;
          ctl.emit_kind  = KIND_DONE;
          ctl.emit_last  = 1'b1;
          ctl.emit_rdata = st.pend_is_load;
          ctl.fill_load  = st.pend_is_load;
          ctl.inc_rq     = st.pend_is_load;
          ctl.fill_store = !st.pend_is_load;
          ctl.inc_wq     = !st.pend_is_load;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dmwbc_dp.sv */
module dmwbc_dp
  import dmwbc_pkg::*;
#(
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  dmwbc_ctl_t  ctl,
  output dmwbc_stat_t st,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  cmd,
  input  logic [31:0] address,
  input  logic [31:0] store_value,
  input  logic [31:0] fill_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] mem_address,
  output logic [31:0] data,
  output logic        hit,
  output logic        last,
  output logic [31:0] read_misses,
  output logic [31:0] write_misses,
  output logic [31:0] read_queries,
  output logic [31:0] write_queries
);

  localparam int AW = ADDR_BITS;

  logic [31:0]          memory_base;
  logic [1:0]           req_cmd;
  logic [AW-1:0]        req_addr;
  logic [31:0]          req_value;
  logic [31:0]          req_fill;

  logic [OFF_BITS-1:0]  req_off;
  logic [AW-1:0]        req_start;
  logic [SET_BITS-1:0]  req_set;
  logic [WORD_BITS-1:0] req_word;

  logic                 pending;
  logic                 pend_load;
  logic [31:0]          pend_value;
  logic [AW-1:0]        pend_start;
  logic [SET_BITS-1:0]  pend_set;
  logic [WORD_BITS-1:0] pend_word;
  logic [WORD_BITS-1:0] fill_count;
  logic [WORD_BITS-1:0] wb_count;

  logic [NUM_SETS-1:0]  line_valid;
  logic [NUM_SETS-1:0]  line_dirty;

  logic [AW-1:0]        tag_mem [NUM_SETS];
  logic [31:0]          data_mem [LINE_WORDS];
  logic [AW-1:0]        tag_rd;
  logic [31:0]          data_rd;

  logic                 rd_en;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_idx;
  logic [31:0]          wr_data;

  logic [31:0]          rm;
  logic [31:0]          wm;
  logic [31:0]          rq;
  logic [31:0]          wq;
  logic [31:0]          rm_next;
  logic [31:0]          wm_next;
  logic [31:0]          rq_next;
  logic [31:0]          wq_next;

  logic [AW-1:0]        wb_addr;

  assign req_off   = req_addr[OFF_BITS-1:0] - memory_base[OFF_BITS-1:0];
  assign req_start = req_addr - AW'(req_off);
  assign req_set   = req_start[OFF_BITS +: SET_BITS];
  assign req_word  = req_off[OFF_BITS-1:2];
  assign wb_addr   = tag_rd + AW'({wb_count, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_base <= '0;
    end else if (cfg_write) begin
      memory_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_cmd   <= cmd;
      req_addr  <= address[AW-1:0];
      req_value <= store_value;
      req_fill  <= fill_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      fill_count <= '0;
      wb_count   <= '0;
      line_valid <= '0;
      line_dirty <= '0;
      rm         <= '0;
      wm         <= '0;
      rq         <= '0;
      wq         <= '0;
    end else begin
      rm <= rm_next;
      wm <= wm_next;
      rq <= rq_next;
      wq <= wq_next;
      if (ctl.hit_store) begin
        line_dirty[req_set] <= 1'b1;
      end
      if (ctl.miss) begin
        line_valid[req_set] <= 1'b0;
        line_dirty[req_set] <= 1'b0;
        pending             <= 1'b1;
        fill_count          <= '0;
        wb_count            <= '0;
      end
      if (ctl.wb_adv) begin
        wb_count <= wb_count + WORD_BITS'(1);
      end
      if (ctl.fill_write && !ctl.fill_finish) begin
        fill_count <= fill_count + WORD_BITS'(1);
      end
      if (ctl.fill_finish) begin
        line_valid[pend_set] <= 1'b1;
        pending              <= 1'b0;
        fill_count           <= '0;
      end
      if (ctl.fill_load) begin
        line_dirty[pend_set] <= 1'b0;
      end
      if (ctl.fill_store) begin
        line_dirty[pend_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.miss) begin
      pend_load  <= (req_cmd == CMD_LOAD);
      pend_value <= req_value;
      pend_start <= req_start;
      pend_set   <= req_set;
      pend_word  <= req_word;
    end
  end

  always_comb begin
    rd_en  = ctl.rd_lookup | ctl.rd_wb | ctl.rd_fill;
    rd_idx = {req_set, req_word};
    if (ctl.rd_wb) begin
      rd_idx = {pend_set, wb_count};
    end else if (ctl.rd_fill) begin
      rd_idx = {pend_set, pend_word};
    end
    wr_en   = ctl.hit_store | ctl.fill_write | ctl.fill_store;
    wr_idx  = {req_set, req_word};
    wr_data = req_value;
    if (ctl.fill_write) begin
      wr_idx  = {pend_set, fill_count};
      wr_data = req_fill;
    end else if (ctl.fill_store) begin
      wr_idx  = {pend_set, pend_word};
      wr_data = pend_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      data_rd <= data_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fill_finish) begin
      tag_mem[pend_set] <= pend_start;
    end
    if (ctl.rd_lookup) begin
      tag_rd <= tag_mem[req_set];
    end
  end

  assign rm_next = rm + 32'(ctl.miss && (req_cmd == CMD_LOAD));
  assign wm_next = wm + 32'(ctl.miss && (req_cmd == CMD_STORE));
  assign rq_next = rq + 32'(ctl.inc_rq);
  assign wq_next = wq + 32'(ctl.inc_wq);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      kind          <= ctl.emit_kind;
      data          <= ctl.emit_rdata ? data_rd : 32'd0;
      hit           <= ctl.emit_hit;
      last          <= ctl.emit_last;
      read_misses   <= rm_next;
      write_misses  <= wm_next;
      read_queries  <= rq_next;
      write_queries <= wq_next;
      case (ctl.emit_kind)
        KIND_WB:  mem_address <= 32'(wb_addr);
        KIND_REQ: mem_address <= 32'(pend_start);
        default:  mem_address <= 32'd0;
      endcase
    end
  end

  assign st.req_cmd      = req_cmd;
  assign st.pending      = pending;
  assign st.hit          = line_valid[req_set] && (tag_rd == req_start);
  assign st.victim_dirty = line_valid[req_set] && line_dirty[req_set];
  assign st.fill_last    = (fill_count == WORD_BITS'(WORDS_PER_BLOCK - 1));
  assign st.wb_last      = (wb_count == WORD_BITS'(WORDS_PER_BLOCK - 1));
  assign st.pend_is_load = pend_load;
  assign st.out_free     = !out_valid || out_ready;

endmodule

/* rtl/direct_mapped_writeback_cache_top.sv */
// Channel   Handshake            Payload
// in        in_valid/in_ready    cmd, address, store_value, fill_word
// out       out_valid/out_ready  kind, mem_address, data, hit, last, miss/query counts
// cfg       cfg_write            cfg_data (memory_base)
//
// One request at a time: a hit, an ignored request or a non-final fill word
// passes through accept, registered tag/data read and compare.
// A miss adds a read and an emit per writeback word of a dirty victim, then
// the fill request; the final fill word adds a data read and the result after compare.
// Reset clears valid and dirty bits at once; no clearing pass.
// A busy output register stalls emission, and no new request is taken meanwhile.
module direct_mapped_writeback_cache_top
  import dmwbc_pkg::*;
#(
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] address,
  input  logic [31:0] store_value,
  input  logic [31:0] fill_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] mem_address,
  output logic [31:0] data,
  output logic        hit,
  output logic        last,
  output logic [31:0] read_misses,
  output logic [31:0] write_misses,
  output logic [31:0] read_queries,
  output logic [31:0] write_queries
);

  dmwbc_ctl_t  ctl;
  dmwbc_stat_t st;

  dmwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  dmwbc_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .st            (st),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .address       (address),
    .store_value   (store_value),
    .fill_word     (fill_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .mem_address   (mem_address),
    .data          (data),
    .hit           (hit),
    .last          (last),
    .read_misses   (read_misses),
    .write_misses  (write_misses),
    .read_queries  (read_queries),
    .write_queries (write_queries)
  );

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> st.out_free)
    else $error("result emitted into a busy output register");

  a_miss_sets_pending: assert property (@(posedge clk) disable iff (rst)
    ctl.miss |=> st.pending)
    else $error("miss did not leave a fill pending");

  a_fill_clears_pending: assert property (@(posedge clk) disable iff (rst)
    ctl.fill_finish |=> !st.pending)
    else $error("final fill word left a fill pending");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule
